/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/btss_pkg.sv */
// ----------------------------------------------------------------------------
// btss_pkg
// Types and operation codes for the bit test / scan / swap unit.
// ----------------------------------------------------------------------------
package btss_pkg;

    localparam logic [2:0] FUNC_BT    = 3'd0;
    localparam logic [2:0] FUNC_BTR   = 3'd1;
    localparam logic [2:0] FUNC_BSWAP = 3'd2;
    localparam logic [2:0] FUNC_BSF   = 3'd3;
    localparam logic [2:0] FUNC_BSR   = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic        narrow;
        logic [31:0] operand_value;
        logic [7:0]  bit_offset;
    } in_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        write_back;
        logic        carry_out;
        logic        carry_valid;
        logic        zero_out;
        logic        zero_valid;
    } out_t;

    // decode stage result
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] val;
        logic [31:0] raw;
        logic [31:0] bit_sel;
    } s1_t;

    // execute stage result
    typedef struct packed {
        logic [2:0]       func;
        logic             tested;
        logic [31:0]      cleared;
        logic [31:0]      swapped;
        logic [3:0]       byte_nz;
        logic [3:0][2:0]  lo_idx;
        logic [3:0][2:0]  hi_idx;
    } s2_t;

endpackage

/* design/x86_bit_test_scan_swap_unit.sv */
// ----------------------------------------------------------------------------
// x86_bit_test_scan_swap_unit
// Execution unit for BT, BTR, BSWAP, BSF and BSR at 16/32-bit operand size.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one instruction per transaction: func,
//   narrow, operand_value and bit_offset.
//   out_valid/out_ready/out_data return one result transaction per
//   instruction, in order: result_value with write_back, carry and zero
//   flags each with a valid mark.
//   Three register stages (decode, execute, resolve): the accepting edge
//   loads decode, then execute and the resolve output register, where
//   out_valid rises. Throughput is one transaction per cycle while out_ready
//   is high, set by the three-stage register pipeline with no shared unit.
//   Reset clears all stage valid bits; the pipeline is empty afterwards.
//   When out_ready is low the output register holds its transaction and
//   earlier stages keep filling until all three are occupied, then
//   in_ready drops. Nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
module x86_bit_test_scan_swap_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  btss_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output btss_pkg::out_t out_data
);
    import btss_pkg::*;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;

    btss_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data)
    );

    btss_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2_data  (s2_data)
    );

    btss_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_ready  (s2_ready),
        .s2_data   (s2_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* design/btss_decode.sv */
// ----------------------------------------------------------------------------
// btss_decode
// Stage 1: operand size masking and bit select decode.
// ----------------------------------------------------------------------------
module btss_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  btss_pkg::in_t in_data,
    output logic          s1_valid,
    input  logic          s1_ready,
    output btss_pkg::s1_t s1_data
);
    import btss_pkg::*;

    logic  valid_reg;
    s1_t   data_reg;
    s1_t   data_next;
    logic [4:0] pos;

    assign in_ready = !valid_reg || s1_ready;
    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

    always_comb
    begin
        pos               = in_data.narrow ? {1'b0, in_data.bit_offset[3:0]}
                                           : in_data.bit_offset[4:0];
        data_next.func    = in_data.func;
        data_next.raw     = in_data.operand_value;
        data_next.val     = in_data.narrow ? {16'h0000, in_data.operand_value[15:0]}
                                           : in_data.operand_value;
        data_next.bit_sel = 32'h0000_0001 << pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/btss_exec.sv */
// ----------------------------------------------------------------------------
// btss_exec
// Stage 2: bit test, bit clear, byte swap and per-byte scan.
// ----------------------------------------------------------------------------
module btss_exec (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s1_valid,
    output logic          s1_ready,
    input  btss_pkg::s1_t s1_data,
    output logic          s2_valid,
    input  logic          s2_ready,
    output btss_pkg::s2_t s2_data
);
    import btss_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    function automatic logic [2:0] low_index8(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
                idx = 3'(i);
        end
        return idx;
    endfunction

    function automatic logic [2:0] high_index8(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                idx = 3'(i);
        end
        return idx;
    endfunction

    assign s1_ready = !valid_reg || s2_ready;
    assign s2_valid = valid_reg;
    assign s2_data  = data_reg;

    always_comb
    begin
        data_next.func    = s1_data.func;
        data_next.tested  = |(s1_data.val & s1_data.bit_sel);
        data_next.cleared = s1_data.val & ~s1_data.bit_sel;
        data_next.swapped = {s1_data.raw[7:0], s1_data.raw[15:8],
                             s1_data.raw[23:16], s1_data.raw[31:24]};
        for (int k = 0; k < 4; k++)
        begin
            data_next.byte_nz[k] = |s1_data.val[k*8 +: 8];
            data_next.lo_idx[k]  = low_index8(s1_data.val[k*8 +: 8]);
            data_next.hi_idx[k]  = high_index8(s1_data.val[k*8 +: 8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/btss_resolve.sv */
// ----------------------------------------------------------------------------
// btss_resolve
// Stage 3: scan byte select, result and flag assembly, output register.
// ----------------------------------------------------------------------------
module btss_resolve (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s2_valid,
    output logic           s2_ready,
    input  btss_pkg::s2_t  s2_data,
    output logic           out_valid,
    input  logic           out_ready,
    output btss_pkg::out_t out_data
);
    import btss_pkg::*;

    logic       valid_reg;
    out_t       data_reg;
    out_t       data_next;
    logic [1:0] lo_byte;
    logic [1:0] hi_byte;
    logic       src_zero;

    assign s2_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        lo_byte = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (s2_data.byte_nz[k])
                lo_byte = 2'(k);
        end
        hi_byte = 2'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (s2_data.byte_nz[k])
                hi_byte = 2'(k);
        end
        src_zero = (s2_data.byte_nz == 4'b0000);

        data_next = '0;
        unique case (s2_data.func)
            FUNC_BT:
            begin
                data_next.carry_out   = s2_data.tested;
                data_next.carry_valid = 1'b1;
            end
            FUNC_BTR:
            begin
                data_next.carry_out    = s2_data.tested;
                data_next.carry_valid  = 1'b1;
                data_next.result_value = s2_data.cleared;
                data_next.write_back   = 1'b1;
            end
            FUNC_BSWAP:
            begin
                data_next.result_value = s2_data.swapped;
                data_next.write_back   = 1'b1;
            end
            FUNC_BSF:
            begin
                data_next.zero_valid = 1'b1;
                data_next.zero_out   = src_zero;
                data_next.write_back = !src_zero;
                if (!src_zero)
                    data_next.result_value = {27'd0, lo_byte, s2_data.lo_idx[lo_byte]};
            end
            FUNC_BSR:
            begin
                data_next.zero_valid = 1'b1;
                data_next.zero_out   = src_zero;
                data_next.write_back = !src_zero;
                if (!src_zero)
                    data_next.result_value = {27'd0, hi_byte, s2_data.hi_idx[hi_byte]};
            end
            default:
            begin
                data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s2_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* design/btss_checker.sv */
// ----------------------------------------------------------------------------
// btss_checker
// Port-level checks for the bit test / scan / swap unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btss_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input btss_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input btss_pkg::out_t out_data
);
    import btss_pkg::*;

    logic       unused_wb;
    logic       both_flags;

    assign unused_wb  = out_valid && !out_data.write_back;
    assign both_flags = out_data.carry_valid && out_data.zero_valid;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `ASSERT_IMPL(a_unused_result, clk, rst_n, unused_wb, out_data.result_value == 32'd0)
    `ASSERT_IMPL(a_flag_groups, clk, rst_n, out_valid, !both_flags)
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_data))

endmodule

bind x86_bit_test_scan_swap_unit btss_checker u_btss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
